FILE: hw/rtl/lru_key_value_cache_top_defines.svh
// assertion macros for the lru key-value cache checker
// no dependencies; expects clk and rst_n in the including scope
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH

// property checked on every rising edge outside reset
`define LKVC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lkvc check failed");

// implication form: trigger on the left, consequence on the right
`define LKVC_ASSERT_IMP(label, trig, cons) \
    `LKVC_ASSERT(label, (trig) |-> (cons))

`endif

FILE: hw/rtl/lkvc_pkg.sv
// shared types and constants for the lru key-value cache
// no dependencies
`default_nettype none

package lkvc_pkg;

    localparam int ENTRIES_DEF  = 16;
    localparam int KEY_BITS_DEF = 16;
    localparam int VAL_W        = 32;
    localparam int CAP_W        = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_SET = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPD
    } lkvc_state_t;

    // control broadcast from the sequencer to the cell row
    typedef struct packed {
        logic look;
        logic upd_fire;
        logic hit_mode;
        logic load_out;
    } lkvc_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lru_key_value_cache_top.sv
// lru key-value cache: row of entry cells kept in recency order plus sequencer
// depends on lkvc_pkg, lkvc_cell, lkvc_ctrl
//
//  channel  | handshake            | beat contents
//  ---------+----------------------+---------------------------
//  input    | in_valid / in_stall  | kind, key, value
//  output   | out_valid / out_stall| hit, read_value
//  config   | cfg_valid / cfg_ready| cfg_data (capacity)
//
// each item gets one compare cycle across all cells and one shift cycle
// in which entries younger than the touched one move one cell along the row
// a get result sits in the output register; if it is still stalled when the
// next get reaches its shift cycle, that cycle repeats until the slot frees
// reset empties the row and sets capacity to 16; no clearing pass is needed
`default_nettype none

module lru_key_value_cache_top #(
    parameter int ENTRIES  = lkvc_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = lkvc_pkg::KEY_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               kind,
    input  wire logic [KEY_BITS-1:0]                key,
    input  wire logic signed [lkvc_pkg::VAL_W-1:0]  value,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    hit,
    output logic signed [lkvc_pkg::VAL_W-1:0]       read_value,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [lkvc_pkg::CAP_W-1:0]         cfg_data
);
    import lkvc_pkg::*;

    logic                kind_reg, kind_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [VAL_W-1:0]    value_reg, value_next;
    logic                out_valid_reg, out_valid_next;
    logic                hit_reg, hit_next;
    logic [VAL_W-1:0]    rdata_reg, rdata_next;

    logic                take;
    logic                out_busy;
    logic                any_hit;
    logic [VAL_W-1:0]    rd_value;
    logic [VAL_W-1:0]    head_value;
    lkvc_ctl_t           ctl;
    logic [ENTRIES-1:0]  miss_shift;

    // chain links: index i feeds cell i, cell i drives index i+1
    logic [KEY_BITS-1:0] link_key   [ENTRIES+1];
    logic [VAL_W-1:0]    link_value [ENTRIES+1];
    logic                link_valid [ENTRIES+1];
    logic                sfx        [ENTRIES+1];
    logic [VAL_W-1:0]    rd_part    [ENTRIES];

    assign take     = in_valid & !in_stall;
    assign out_busy = out_valid_reg & out_stall;
    assign any_hit  = sfx[0];

    lkvc_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .kind_q     (kind_reg),
        .hit        (any_hit),
        .out_busy   (out_busy),
        .ctl        (ctl),
        .miss_shift (miss_shift)
    );

    // head of the row: the touched or new entry always lands in cell 0
    assign head_value    = (kind_reg == KIND_SET) ? value_reg : rd_value;
    assign link_key[0]   = key_reg;
    assign link_value[0] = head_value;
    assign link_valid[0] = 1'b1;
    assign sfx[ENTRIES]  = 1'b0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lkvc_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .req_key    (key_reg),
            .src_key    (link_key[i]),
            .src_value  (link_value[i]),
            .src_valid  (link_valid[i]),
            .sfx_in     (sfx[i+1]),
            .miss_shift (miss_shift[i]),
            .ent_key    (link_key[i+1]),
            .ent_value  (link_value[i+1]),
            .ent_valid  (link_valid[i+1]),
            .sfx_out    (sfx[i]),
            .rd_part    (rd_part[i])
        );
    end

    // at most one cell matches, so an or across the row is the readout
    always_comb
    begin
        rd_value = '0;
        for (int i = 0; i < ENTRIES; i++)
            rd_value = rd_value | rd_part[i];
    end

    always_comb
    begin
        kind_next      = take ? kind : kind_reg;
        key_next       = take ? key : key_reg;
        value_next     = take ? value : value_reg;
        out_valid_next = ctl.load_out | out_busy;
        hit_next       = ctl.load_out ? any_hit : hit_reg;
        rdata_next     = ctl.load_out ? rd_value : rdata_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        key_reg   <= key_next;
        value_reg <= value_next;
        hit_reg   <= hit_next;
        rdata_reg <= rdata_next;
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign read_value = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/lkvc_cell.sv
// one cache entry of the recency-ordered row: key, value, valid and match flag
// depends on lkvc_pkg
`default_nettype none

module lkvc_cell #(
    parameter int KEY_BITS = lkvc_pkg::KEY_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire lkvc_pkg::lkvc_ctl_t         ctl,
    input  wire logic [KEY_BITS-1:0]         req_key,
    input  wire logic [KEY_BITS-1:0]         src_key,
    input  wire logic [lkvc_pkg::VAL_W-1:0]  src_value,
    input  wire logic                        src_valid,
    input  wire logic                        sfx_in,
    input  wire logic                        miss_shift,
    output logic [KEY_BITS-1:0]              ent_key,
    output logic [lkvc_pkg::VAL_W-1:0]       ent_value,
    output logic                             ent_valid,
    output logic                             sfx_out,
    output logic [lkvc_pkg::VAL_W-1:0]       rd_part
);
    import lkvc_pkg::*;

    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [VAL_W-1:0]    value_reg, value_next;
    logic                valid_reg, valid_next;
    logic                match_reg, match_next;
    logic                load;

    // on a hit every cell at or below the hit position moves one step older
    assign sfx_out = match_reg | sfx_in;
    assign load    = ctl.upd_fire & (ctl.hit_mode ? sfx_out : miss_shift);
    assign rd_part = match_reg ? value_reg : '0;

    always_comb
    begin
        key_next   = load ? src_key : key_reg;
        value_next = load ? src_value : value_reg;
        valid_next = load ? src_valid : valid_reg;
        match_next = ctl.look ? (valid_reg & (key_reg == req_key)) : match_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign ent_key   = key_reg;
    assign ent_value = value_reg;
    assign ent_valid = valid_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/lkvc_ctrl.sv
// sequencer for the cache: compare and update phases, capacity and occupancy
// depends on lkvc_pkg
`default_nettype none

module lkvc_ctrl #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [lkvc_pkg::CAP_W-1:0]  cfg_data,
    input  wire logic                        kind_q,
    input  wire logic                        hit,
    input  wire logic                        out_busy,
    output lkvc_pkg::lkvc_ctl_t              ctl,
    output logic [ENTRIES-1:0]               miss_shift
);
    import lkvc_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int LW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    lkvc_state_t      state_reg, state_next;
    logic [CAP_W-1:0] cap_reg, cap_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [LW-1:0]    cap_w, limit_w;
    logic [CNT_W-1:0] lim_idx;
    logic             upd_ok;
    logic             evict;
    logic             grow;

    assign cfg_ready = 1'b1;
    assign upd_ok    = (kind_q == KIND_SET) | !out_busy;

    // capacity zero acts as one, above the row length it saturates
    always_comb
    begin
        cap_w = LW'(cap_reg);
        if (cap_w == '0)
            limit_w = LW'(1);
        else if (cap_w > LW'(ENTRIES))
            limit_w = LW'(ENTRIES);
        else
            limit_w = cap_w;
    end

    assign evict   = LW'(occ_reg) >= limit_w;
    assign lim_idx = evict ? (occ_reg - CNT_W'(1)) : occ_reg;
    assign grow    = (state_reg == ST_UPD) & upd_ok & (kind_q == KIND_SET) & !hit & !evict;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
            miss_shift[i] = CNT_W'(i) <= lim_idx;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_LOOK;
            ST_LOOK:
                state_next = ST_UPD;
            ST_UPD:
                if (upd_ok)
                    state_next = in_valid ? ST_LOOK : ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ctl      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
                in_stall = 1'b0;
            ST_LOOK:
                ctl.look = 1'b1;
            ST_UPD:
            begin
                in_stall     = !upd_ok;
                ctl.hit_mode = hit;
                ctl.upd_fire = upd_ok & ((kind_q == KIND_SET) | hit);
                ctl.load_out = upd_ok & (kind_q == KIND_GET);
            end
            default:
                in_stall = 1'b1;
        endcase
    end

    always_comb
    begin
        cap_next = (cfg_valid & cfg_ready) ? cfg_data : cap_reg;
        occ_next = grow ? (occ_reg + CNT_W'(1)) : occ_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cap_reg   <= CAP_RESET;
            occ_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cap_reg   <= cap_next;
            occ_reg   <= occ_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lkvc_checker.sv
// port-level checks for the lru key-value cache, bound to the top level
// depends on lkvc_pkg and lru_key_value_cache_top_defines.svh
`default_nettype none
`include "lru_key_value_cache_top_defines.svh"

module lkvc_checker #(
    parameter int KEY_BITS = lkvc_pkg::KEY_BITS_DEF
) (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_valid,
    input wire logic                               in_stall,
    input wire logic                               kind,
    input wire logic [KEY_BITS-1:0]                key,
    input wire logic signed [lkvc_pkg::VAL_W-1:0]  value,
    input wire logic                               out_valid,
    input wire logic                               out_stall,
    input wire logic                               hit,
    input wire logic signed [lkvc_pkg::VAL_W-1:0]  read_value
);
    import lkvc_pkg::*;

    // a held result beat keeps its contents
    `LKVC_ASSERT(a_out_hold, out_valid & out_stall |=> out_valid & $stable({hit, read_value}))

    // a held input beat keeps its contents
    `LKVC_ASSERT(a_in_hold, in_valid & in_stall |=> in_valid & $stable({kind, key, value}))

    // a miss always reads back zero
    `LKVC_ASSERT_IMP(a_miss_zero, (out_valid & !hit), (read_value == '0))

    // an accepted beat is always followed by the compare cycle
    `LKVC_ASSERT(a_one_per_look, (in_valid & !in_stall) |=> in_stall)

    // a fresh result is only loaded in an update cycle that completes
    `LKVC_ASSERT_IMP(a_out_from_upd, $rose(out_valid), !$past(in_stall))

endmodule

bind lru_key_value_cache_top lkvc_checker #(
    .KEY_BITS (KEY_BITS)
) u_lkvc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .key        (key),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hit        (hit),
    .read_value (read_value)
);

`default_nettype wire
